FILE: rtl/fsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsg_pkg
// Shared types and constants for the falling sand grid engine.
// ----------------------------------------------------------------------------
package fsg_pkg;

   // Field and register widths.
   localparam int DIM_W = 9;
   localparam int CNT_W = 17;
   localparam int COORD_W = 8;
   localparam int OP_W = 2;
   localparam int CSR_IDX_W = 1;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_SET = 2'd0;
   localparam logic [OP_W-1:0] OP_GET = 2'd1;
   localparam logic [OP_W-1:0] OP_FRAME = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'd1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_RD_BELOW,
      ST_LD_BELOW,
      ST_RD_CUR,
      ST_LD_CUR,
      ST_SCAN,
      ST_WR_BELOW,
      ST_WR_LAST,
      ST_FINISH
   } fsg_state_type;

   // Per-cell context handed to the move unit during a row scan.
   typedef struct packed {
      logic [DIM_W-1:0] x;
      logic [DIM_W-1:0] width;
      logic             left_first;
   } fsg_scan_type;

endpackage

FILE: rtl/fsg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/fsg_move_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsg_move_unit
// Decides the move of one grain and returns the updated current and lower rows.
// ----------------------------------------------------------------------------
module fsg_move_unit
   import fsg_pkg::*;
#(
   parameter int MAX_WIDTH = 256
) (
   input  fsg_scan_type         scan,
   input  logic [MAX_WIDTH-1:0] cur_row,
   input  logic [MAX_WIDTH-1:0] below_row,
   output logic [MAX_WIDTH-1:0] cur_next,
   output logic [MAX_WIDTH-1:0] below_next
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [DIM_W-1:0] x_left;
   logic [DIM_W-1:0] x_right;
   logic [CW-1:0]    idx_here;
   logic [CW-1:0]    idx_left;
   logic [CW-1:0]    idx_right;
   logic             grain;
   logic             down_free;
   logic             left_free;
   logic             right_free;
   logic             move;
   logic [CW-1:0]    target;

   assign x_left = scan.x - DIM_W'(1);
   assign x_right = scan.x + DIM_W'(1);
   assign idx_here = CW'(scan.x);
   assign idx_left = CW'(x_left);
   assign idx_right = CW'(x_right);

   // Free target cells; diagonals must stay inside the columns in use.
   assign grain = cur_row[idx_here];
   assign down_free = !below_row[idx_here];
   assign left_free = (scan.x != '0) && !below_row[idx_left];
   assign right_free = (x_right < scan.width) && !below_row[idx_right];

   // Straight down first, then the preferred diagonal, then the other one.
   always_comb begin
      move = 1'b0;
      target = idx_here;
      if (grain) begin
         if (down_free) begin
            move = 1'b1;
         end else if (scan.left_first) begin
            if (left_free) begin
               move = 1'b1;
               target = idx_left;
            end else if (right_free) begin
               move = 1'b1;
               target = idx_right;
            end
         end else begin
            if (right_free) begin
               move = 1'b1;
               target = idx_right;
            end else if (left_free) begin
               move = 1'b1;
               target = idx_left;
            end
         end
      end
   end

   // Apply the move to both rows.
   always_comb begin
      cur_next = cur_row;
      below_next = below_row;
      if (move) begin
         cur_next[idx_here] = 1'b0;
         below_next[target] = 1'b1;
      end
   end

endmodule

FILE: rtl/falling_sand_grid_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falling_sand_grid_step
// Falling sand grid: set and get cells, and step the whole grid one frame.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ channel, one beat per operation, and each
//   gives exactly one response beat on the rsp_ channel. The csr_ channel
//   writes the grid width (index 0) and height (index 1); it is always ready
//   and should only be written while no request is in flight.
//   The grid is kept as one memory word per row. Set and get read the row,
//   modify and write it back, and respond. A frame walks the rows from the
//   bottom up with one cell per cycle in the shared move unit.
//   The request channel is ready only in the idle state, so one operation is
//   processed at a time; a finished response may wait in the output register
//   while the next request is taken.
//   After reset a clearing pass writes MAX_HEIGHT rows of zeros, one row per
//   cycle, before the first request is accepted.
//   When the receiver stalls, the response holds and a following operation
//   waits at its end until the output register is free.
// ----------------------------------------------------------------------------
module falling_sand_grid_step
   import fsg_pkg::*;
#(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [COORD_W-1:0]   req_col,
   input  logic [COORD_W-1:0]   req_row,
   input  logic                 req_cell_in,
   input  logic                 req_frame_parity,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_cell_out,
   output logic                 rsp_coord_ok,
   output logic [CNT_W-1:0]     rsp_sand_total,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam logic [DIM_W-1:0] MAXW9 = (MAX_WIDTH > 511) ? 9'd511 : DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAXH9 = (MAX_HEIGHT > 511) ? 9'd511 : DIM_W'(MAX_HEIGHT);
   localparam logic [RW-1:0] LAST_ROW = RW'(MAX_HEIGHT - 1);
   localparam logic [DIM_W-1:0] RESET_DIM = 9'd256;

   fsg_state_type state_ff, state_in;

   logic [OP_W-1:0]      op_ff, op_in;
   logic [COORD_W-1:0]   col_ff, col_in;
   logic [COORD_W-1:0]   row_ff, row_in;
   logic                 cellv_ff, cellv_in;
   logic                 par_ff, par_in;
   logic [DIM_W-1:0]     width_ff, width_in;
   logic [DIM_W-1:0]     height_ff, height_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DIM_W-1:0]     y_ff, y_in;
   logic [DIM_W-1:0]     k_ff, k_in;
   logic [MAX_WIDTH-1:0] cur_ff, cur_in;
   logic [MAX_WIDTH-1:0] below_ff, below_in;
   logic [RW-1:0]        clr_ff, clr_in;
   logic                 res_cell_ff, res_cell_in;
   logic                 res_ok_ff, res_ok_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_cell_ff, rsp_cell_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [CNT_W-1:0]     rsp_total_ff, rsp_total_in;

   logic [DIM_W-1:0]     eff_w;
   logic [DIM_W-1:0]     eff_h;
   logic                 coord_ok;
   logic [CW-1:0]        col_idx;
   logic                 old_cell;
   logic                 set_change;
   logic [MAX_WIDTH-1:0] set_row;
   logic                 frame_empty;
   logic                 out_load;

   logic                 ram_wr_en;
   logic [RW-1:0]        ram_wr_addr;
   logic [MAX_WIDTH-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [RW-1:0]        ram_rd_addr;
   logic [MAX_WIDTH-1:0] ram_rd_data;

   fsg_scan_type         scan;
   logic [DIM_W-1:0]     scan_x;
   logic [MAX_WIDTH-1:0] cur_next;
   logic [MAX_WIDTH-1:0] below_next;

   // Row memory, one word per grid row.
   fsg_ram #(
      .WIDTH (MAX_WIDTH),
      .DEPTH (MAX_HEIGHT)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared cell move unit used once per scan cycle.
   assign scan_x = par_ff ? (eff_w - DIM_W'(1) - k_ff) : k_ff;
   assign scan.x = scan_x;
   assign scan.width = eff_w;
   assign scan.left_first = scan_x[0] ^ y_ff[0] ^ par_ff;

   fsg_move_unit #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_move (
      .scan       (scan),
      .cur_row    (cur_ff),
      .below_row  (below_ff),
      .cur_next   (cur_next),
      .below_next (below_next)
   );

   // Dimensions in use, saturated to the storage size.
   assign eff_w = (width_ff > MAXW9) ? MAXW9 : width_ff;
   assign eff_h = (height_ff > MAXH9) ? MAXH9 : height_ff;
   assign frame_empty = (eff_h < DIM_W'(2)) || (eff_w == '0);

   // Cell access for set and get on the row just read.
   assign coord_ok = ({1'b0, col_ff} < eff_w) && ({1'b0, row_ff} < eff_h);
   assign col_idx = CW'(col_ff);
   assign old_cell = ram_rd_data[col_idx];
   assign set_change = (op_ff == OP_SET) && coord_ok && (old_cell != cellv_ff);

   always_comb begin
      set_row = ram_rd_data;
      set_row[col_idx] = cellv_ff;
   end

   assign out_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  OP_SET, OP_GET: state_in = ST_ACCESS;
                  OP_FRAME: state_in = frame_empty ? ST_FINISH : ST_RD_BELOW;
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_ACCESS: state_in = ST_FINISH;
         ST_RD_BELOW: state_in = ST_LD_BELOW;
         ST_LD_BELOW: state_in = ST_RD_CUR;
         ST_RD_CUR: state_in = ST_LD_CUR;
         ST_LD_CUR: state_in = ST_SCAN;
         ST_SCAN: begin
            if (k_ff == eff_w - DIM_W'(1)) begin
               state_in = ST_WR_BELOW;
            end
         end
         ST_WR_BELOW: begin
            state_in = (y_ff == '0) ? ST_WR_LAST : ST_RD_CUR;
         end
         ST_WR_LAST: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and memory port control.
   always_comb begin
      req_ready = 1'b0;
      ram_rd_en = 1'b0;
      ram_rd_addr = RW'(req_row);
      ram_wr_en = 1'b0;
      ram_wr_addr = RW'(y_ff);
      ram_wr_data = below_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            ram_rd_en = req_valid;
         end
         ST_ACCESS: begin
            ram_wr_en = set_change;
            ram_wr_addr = RW'(row_ff);
            ram_wr_data = set_row;
         end
         ST_RD_BELOW: begin
            ram_rd_en = 1'b1;
            ram_rd_addr = RW'(eff_h - DIM_W'(1));
         end
         ST_RD_CUR: begin
            ram_rd_en = 1'b1;
            ram_rd_addr = RW'(y_ff);
         end
         ST_WR_BELOW: begin
            ram_wr_en = 1'b1;
            ram_wr_addr = RW'(y_ff + DIM_W'(1));
         end
         ST_WR_LAST: begin
            ram_wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign csr_ready = 1'b1;

   // Datapath next values.
   always_comb begin
      op_in = op_ff;
      col_in = col_ff;
      row_in = row_ff;
      cellv_in = cellv_ff;
      par_in = par_ff;
      width_in = width_ff;
      height_in = height_ff;
      count_in = count_ff;
      y_in = y_ff;
      k_in = k_ff;
      cur_in = cur_ff;
      below_in = below_ff;
      clr_in = clr_ff;
      res_cell_in = res_cell_ff;
      res_ok_in = res_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cell_in = rsp_cell_ff;
      rsp_ok_in = rsp_ok_ff;
      rsp_total_in = rsp_total_ff;

      // Configuration writes.
      if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH: width_in = csr_data;
            CSR_HEIGHT: height_in = csr_data;
            default: begin
            end
         endcase
      end

      // Output register.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_cell_in = res_cell_ff;
         rsp_ok_in = res_ok_ff;
         rsp_total_in = count_ff;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + RW'(1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_operation;
               col_in = req_col;
               row_in = req_row;
               cellv_in = req_cell_in;
               par_in = req_frame_parity;
               y_in = eff_h - DIM_W'(2);
               res_cell_in = 1'b0;
               res_ok_in = 1'b0;
            end
         end
         ST_ACCESS: begin
            res_ok_in = coord_ok;
            res_cell_in = coord_ok && ((op_ff == OP_SET) ? cellv_ff : old_cell);
            if (set_change) begin
               count_in = cellv_ff ? (count_ff + CNT_W'(1)) : (count_ff - CNT_W'(1));
            end
         end
         ST_LD_BELOW: begin
            below_in = ram_rd_data;
         end
         ST_LD_CUR: begin
            cur_in = ram_rd_data;
            k_in = '0;
         end
         ST_SCAN: begin
            cur_in = cur_next;
            below_in = below_next;
            k_in = k_ff + DIM_W'(1);
         end
         ST_WR_BELOW: begin
            below_in = cur_ff;
            if (y_ff != '0) begin
               y_in = y_ff - DIM_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         width_ff <= RESET_DIM;
         height_ff <= RESET_DIM;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         width_ff <= width_in;
         height_ff <= height_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      col_ff <= col_in;
      row_ff <= row_in;
      cellv_ff <= cellv_in;
      par_ff <= par_in;
      y_ff <= y_in;
      k_ff <= k_in;
      cur_ff <= cur_in;
      below_ff <= below_in;
      res_cell_ff <= res_cell_in;
      res_ok_ff <= res_ok_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell_out = rsp_cell_ff;
   assign rsp_coord_ok = rsp_ok_ff;
   assign rsp_sand_total = rsp_total_ff;

endmodule
